// ----- hdl/bdcq_pkg.sv -----
// Package for the balanced dual character queue.
// Holds the shared byte constants, operation codes and the lane control and status types.
// Depends on nothing; the lane, the top level and the testbench import it.
`default_nettype none

package bdcq_pkg;

    // Filler character held by every unused slot.
    localparam logic [7:0] DASH = 8'h2D;

    // Operation codes carried by the kind field.
    typedef enum logic {
        OP_ENQUEUE = 1'b0,
        OP_DEQUEUE = 1'b1
    } t_op;

    // Queue selector codes.
    localparam logic QUEUE_A = 1'b0;
    localparam logic QUEUE_B = 1'b1;

    // Commands from the arbiter to one queue lane.
    typedef struct packed {
        logic       push;
        logic       pop;
        logic [7:0] data;
    } t_lane_ctrl;

    // Characters that one lane reports: its present head and its state after the update.
    typedef struct packed {
        logic [7:0] head;
        logic [7:0] next_front;
        logic [7:0] next_back;
    } t_lane_stat;

    // Registered result of one transaction.
    typedef struct packed {
        logic [7:0] data_out;
        logic       was_empty;
        logic       dropped;
        logic       chosen_queue;
        logic [3:0] count_a;
        logic [3:0] count_b;
        logic [7:0] front_a;
        logic [7:0] front_b;
        logic [7:0] back_a;
        logic [7:0] back_b;
    } t_result;

endpackage

`default_nettype wire

// ----- hdl/bdcq_if.sv -----
// Channel interfaces of the balanced dual character queue: command in, result out.
// Both carry valid, ready and the payload; they depend on nothing else.
`default_nettype none

interface bdcq_cmd_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_in;

    modport source (output valid, output kind, output data_in, input ready);
    modport sink   (input valid, input kind, input data_in, output ready);
endinterface

interface bdcq_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_out;
    logic       was_empty;
    logic       dropped;
    logic       chosen_queue;
    logic [3:0] count_a;
    logic [3:0] count_b;
    logic [7:0] front_a;
    logic [7:0] front_b;
    logic [7:0] back_a;
    logic [7:0] back_b;

    modport source (output valid, output data_out, output was_empty, output dropped,
                    output chosen_queue, output count_a, output count_b, output front_a,
                    output front_b, output back_a, output back_b, input ready);
    modport sink   (input valid, input data_out, input was_empty, input dropped,
                    input chosen_queue, input count_a, input count_b, input front_a,
                    input front_b, input back_a, input back_b, output ready);
endinterface

`default_nettype wire

// ----- hdl/bdcq_lane.sv -----
// One shifting byte queue lane: front at slot zero, removal shifts every slot forward.
// Depends on bdcq_pkg for the dash constant and the lane control and status types.
`default_nettype none

module bdcq_lane
    import bdcq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 8,
    parameter int CW          = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  t_lane_ctrl         i_ctrl,
    output logic [CW-1:0]      o_count,
    output logic [CW-1:0]      o_next_count,
    output t_lane_stat         o_stat
);

    logic [7:0]    r_slots [QUEUE_DEPTH];
    logic [7:0]    n_slots [QUEUE_DEPTH];
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [7:0]    r_back;
    logic [7:0]    n_back;

    // Slot update: a push writes the first free slot, a pop shifts all slots forward.
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            n_slots[i] = r_slots[i];
            if (i_ctrl.pop) begin
                if (i < QUEUE_DEPTH - 1) begin
                    n_slots[i] = r_slots[(i + 1) % QUEUE_DEPTH];
                end else begin
                    n_slots[i] = DASH;
                end
            end else if (i_ctrl.push && (r_count == CW'(i))) begin
                n_slots[i] = i_ctrl.data;
            end
        end
    end

    // Fill count and tail character follow the same command.
    always_comb begin
        n_count = r_count;
        n_back  = r_back;
        if (i_ctrl.push) begin
            n_count = r_count + CW'(1);
            n_back  = i_ctrl.data;
        end else if (i_ctrl.pop) begin
            n_count = r_count - CW'(1);
            if (r_count == CW'(1)) begin
                n_back = DASH;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                r_slots[i] <= DASH;
            end
            r_count <= '0;
            r_back  <= DASH;
        end else begin
            r_slots <= n_slots;
            r_count <= n_count;
            r_back  <= n_back;
        end
    end

    // Empty slots hold dash, so slot zero is the front character in every case.
    assign o_count           = r_count;
    assign o_next_count      = n_count;
    assign o_stat.head       = r_slots[0];
    assign o_stat.next_front = n_slots[0];
    assign o_stat.next_back  = n_back;

endmodule

`default_nettype wire

// ----- hdl/balanced_dual_char_queue.sv -----
// Top level of the balanced dual character queue: arbiter, two queue lanes and result register.
// Depends on bdcq_pkg, the channel interfaces in bdcq_if and the bdcq_lane module.
//
// The block holds two byte queues, A and B, each QUEUE_DEPTH slots deep, and handles one
// command transaction per clock cycle whenever the result register is empty or being drained.
// An enqueue goes to the shorter queue (ties to A, and to the other queue when one is full;
// dropped is flagged when both are full). A dequeue takes from the longer queue (ties to A)
// and returns dash (0x2D) with was_empty set when both are empty. Every command yields exactly
// one result, registered and shown in the cycle after acceptance, carrying both counts (modulo
// 16) and the front and back characters of both queues. The queue choice and the parallel
// slot shift are combinational, so the single result register sets the rate.
`default_nettype none

module balanced_dual_char_queue
    import bdcq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 8
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    bdcq_cmd_if.sink  i_cmd,
    bdcq_res_if.source o_res
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

    logic          accept;
    logic [CW-1:0] count_a;
    logic [CW-1:0] count_b;
    logic [CW-1:0] next_count_a;
    logic [CW-1:0] next_count_b;
    logic          full_a;
    logic          full_b;
    logic          drop;
    logic          empty;
    logic          pick;
    t_lane_ctrl    ctrl_a;
    t_lane_ctrl    ctrl_b;
    t_lane_stat    stat_a;
    t_lane_stat    stat_b;
    t_result       n_res;
    t_result       r_res;
    logic          r_valid;

    // A command is taken whenever the result register is free or being drained.
    assign i_cmd.ready = !r_valid || o_res.ready;
    assign accept      = i_cmd.valid && i_cmd.ready;

    assign full_a = (count_a == DEPTH_C);
    assign full_b = (count_b == DEPTH_C);

    // Queue choice for both operations.
    always_comb begin
        drop  = 1'b0;
        empty = 1'b0;
        pick  = QUEUE_A;
        if (t_op'(i_cmd.kind) == OP_ENQUEUE) begin
            if (full_a && full_b) begin
                drop = 1'b1;
            end else if (full_a) begin
                pick = QUEUE_B;
            end else if (full_b) begin
                pick = QUEUE_A;
            end else begin
                pick = (count_a <= count_b) ? QUEUE_A : QUEUE_B;
            end
        end else begin
            if ((count_a == '0) && (count_b == '0)) begin
                empty = 1'b1;
            end else begin
                pick = (count_a >= count_b) ? QUEUE_A : QUEUE_B;
            end
        end
    end

    // Lane commands.
    always_comb begin
        ctrl_a.data = i_cmd.data_in;
        ctrl_b.data = i_cmd.data_in;
        ctrl_a.push = accept && (t_op'(i_cmd.kind) == OP_ENQUEUE) && !drop && (pick == QUEUE_A);
        ctrl_b.push = accept && (t_op'(i_cmd.kind) == OP_ENQUEUE) && !drop && (pick == QUEUE_B);
        ctrl_a.pop  = accept && (t_op'(i_cmd.kind) == OP_DEQUEUE) && !empty && (pick == QUEUE_A);
        ctrl_b.pop  = accept && (t_op'(i_cmd.kind) == OP_DEQUEUE) && !empty && (pick == QUEUE_B);
    end

    bdcq_lane #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .CW          (CW)
    ) u_lane_a (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (ctrl_a),
        .o_count      (count_a),
        .o_next_count (next_count_a),
        .o_stat       (stat_a)
    );

    bdcq_lane #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .CW          (CW)
    ) u_lane_b (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (ctrl_b),
        .o_count      (count_b),
        .o_next_count (next_count_b),
        .o_stat       (stat_b)
    );

    // Result of the transaction: the popped head, and the lane states after the update.
    always_comb begin
        n_res.data_out     = DASH;
        if (ctrl_a.pop) begin
            n_res.data_out = stat_a.head;
        end else if (ctrl_b.pop) begin
            n_res.data_out = stat_b.head;
        end
        n_res.was_empty    = (t_op'(i_cmd.kind) == OP_DEQUEUE) && empty;
        n_res.dropped      = (t_op'(i_cmd.kind) == OP_ENQUEUE) && drop;
        n_res.chosen_queue = pick;
        n_res.count_a      = 4'(next_count_a);
        n_res.count_b      = 4'(next_count_b);
        n_res.front_a      = stat_a.next_front;
        n_res.front_b      = stat_b.next_front;
        n_res.back_a       = stat_a.next_back;
        n_res.back_b       = stat_b.next_back;
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid        = r_valid;
    assign o_res.data_out     = r_res.data_out;
    assign o_res.was_empty    = r_res.was_empty;
    assign o_res.dropped      = r_res.dropped;
    assign o_res.chosen_queue = r_res.chosen_queue;
    assign o_res.count_a      = r_res.count_a;
    assign o_res.count_b      = r_res.count_b;
    assign o_res.front_a      = r_res.front_a;
    assign o_res.front_b      = r_res.front_b;
    assign o_res.back_a       = r_res.back_a;
    assign o_res.back_b       = r_res.back_b;

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for the balanced dual character queue.
// Drives commands through bdcq_cmd_if, checks every result on bdcq_res_if against a local
// model of both queues; depends on bdcq_pkg, bdcq_if and the balanced_dual_char_queue RTL.
`default_nettype none

module tb_top;
    import bdcq_pkg::*;

    localparam int DEPTH = 8;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bdcq_cmd_if cmd_ch();
    bdcq_res_if res_ch();

    balanced_dual_char_queue #(
        .QUEUE_DEPTH(DEPTH)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd_ch),
        .o_res  (res_ch)
    );

    // Local copy of both queues: index 0 is queue A, index 1 is queue B.
    logic [7:0]  lane_bytes [2][DEPTH];
    int unsigned lane_len [2];

    // Results still owed by the block, oldest first.
    t_result     pending_results [$];

    int unsigned errors        = 0;
    int unsigned items_sent    = 0;
    int unsigned results_seen  = 0;
    int unsigned drops_seen    = 0;
    int unsigned empties_seen  = 0;
    bit          calm          = 1'b0;

    // Free-running clock, period 20.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #4000000;
        $display("Timeout: the run did not complete in time.");
        $display("*** FAILED ***");
        $finish;
    end

    // Result side back-pressure, changed on the falling edge.
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            res_ch.ready <= calm || ($urandom_range(0, 99) >= 19);
        end
    end

    // One line and one count per mismatch.
    task automatic flag_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
        errors++;
        $display("MISMATCH %s at %0t: got 0x%0h, want 0x%0h", what, $time, got, want);
    endtask

    function automatic logic [7:0] lane_front(input int side);
        return (lane_len[side] == 0) ? DASH : lane_bytes[side][0];
    endfunction

    function automatic logic [7:0] lane_back(input int side);
        return (lane_len[side] == 0) ? DASH : lane_bytes[side][lane_len[side] - 1];
    endfunction

    // Apply one command to the local queues and return the result it should produce.
    function automatic t_result predict_queue_op(input t_op op, input logic [7:0] ch);
        t_result r;
        logic    side;
        int      i;
        r          = '0;
        r.data_out = DASH;
        side       = QUEUE_A;
        if (op == OP_ENQUEUE) begin
            if (lane_len[0] >= DEPTH && lane_len[1] >= DEPTH) begin
                r.dropped = 1'b1;
            end else begin
                if (lane_len[0] >= DEPTH)
                    side = QUEUE_B;
                else if (lane_len[1] >= DEPTH)
                    side = QUEUE_A;
                else
                    side = (lane_len[0] <= lane_len[1]) ? QUEUE_A : QUEUE_B;
                r.chosen_queue = side;
                lane_bytes[side][lane_len[side]] = ch;
                lane_len[side]++;
            end
        end else if (lane_len[0] == 0 && lane_len[1] == 0) begin
            r.was_empty = 1'b1;
        end else begin
            side           = (lane_len[0] >= lane_len[1]) ? QUEUE_A : QUEUE_B;
            r.chosen_queue = side;
            r.data_out     = lane_bytes[side][0];
            for (i = 0; i + 1 < int'(lane_len[side]); i++)
                lane_bytes[side][i] = lane_bytes[side][i + 1];
            lane_bytes[side][lane_len[side] - 1] = DASH;
            lane_len[side]--;
        end
        r.count_a = 4'(lane_len[0]);
        r.count_b = 4'(lane_len[1]);
        r.front_a = lane_front(0);
        r.front_b = lane_front(1);
        r.back_a  = lane_back(0);
        r.back_b  = lane_back(1);
        return r;
    endfunction

    // Compare one accepted result with the oldest expectation.
    task automatic check_result(input t_result got);
        t_result want;
        if (pending_results.size() == 0) begin
            flag_mismatch("result with nothing expected", 1, 0);
            return;
        end
        want = pending_results.pop_front();
        results_seen++;
        if (want.dropped)
            drops_seen++;
        if (want.was_empty)
            empties_seen++;
        if (got.data_out != want.data_out)
            flag_mismatch("data_out", got.data_out, want.data_out);
        if (got.was_empty != want.was_empty)
            flag_mismatch("was_empty", got.was_empty, want.was_empty);
        if (got.dropped != want.dropped)
            flag_mismatch("dropped", got.dropped, want.dropped);
        if (got.chosen_queue != want.chosen_queue)
            flag_mismatch("chosen_queue", got.chosen_queue, want.chosen_queue);
        if (got.count_a != want.count_a)
            flag_mismatch("count_a", got.count_a, want.count_a);
        if (got.count_b != want.count_b)
            flag_mismatch("count_b", got.count_b, want.count_b);
        if (got.front_a != want.front_a)
            flag_mismatch("front_a", got.front_a, want.front_a);
        if (got.front_b != want.front_b)
            flag_mismatch("front_b", got.front_b, want.front_b);
        if (got.back_a != want.back_a)
            flag_mismatch("back_a", got.back_a, want.back_a);
        if (got.back_b != want.back_b)
            flag_mismatch("back_b", got.back_b, want.back_b);
    endtask

    // Every result transaction is checked at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready)
            check_result('{res_ch.data_out, res_ch.was_empty, res_ch.dropped,
                           res_ch.chosen_queue, res_ch.count_a, res_ch.count_b,
                           res_ch.front_a, res_ch.front_b, res_ch.back_a, res_ch.back_b});
    end

    // Send one command; entered and left on a falling edge.
    task automatic send_cmd(input t_op op, input logic [7:0] ch);
        while (!calm && $urandom_range(0, 99) < 19) begin
            cmd_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.kind    <= op;
        cmd_ch.data_in <= ch;
        do
            @(posedge i_clk);
        while (!cmd_ch.ready);
        pending_results.push_back(predict_queue_op(op, ch));
        items_sent++;
        @(negedge i_clk);
    endtask

    // Dequeues with both queues empty must leave everything untouched.
    task automatic test_empty_dequeue();
        send_cmd(OP_DEQUEUE, 8'hFF);
        send_cmd(OP_DEQUEUE, 8'h00);
    endtask

    // Fill both queues with edge-case bytes, then hit the full and tie-break cases.
    task automatic test_fill_and_drop();
        logic [7:0] patterns [16] = '{8'h00, 8'hFF, 8'h2D, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'h55,
                                      8'hAA, 8'h0F, 8'hF0, 8'h2C, 8'h2E, 8'h40, 8'hBF, 8'h11};
        int i;
        for (i = 0; i < 16; i++)
            send_cmd(OP_ENQUEUE, patterns[i]);
        // Both full: the byte is discarded.
        send_cmd(OP_ENQUEUE, 8'hC3);
        // Both full on dequeue goes to A, then B is the longer one.
        send_cmd(OP_DEQUEUE, 8'h00);
        send_cmd(OP_DEQUEUE, 8'h00);
        // Tie goes to A, then A is full and B takes the byte.
        send_cmd(OP_ENQUEUE, 8'h3C);
        send_cmd(OP_ENQUEUE, 8'h99);
    endtask

    // Bursts with a random enqueue bias, so the queues swing between full and empty.
    task automatic test_random_traffic(input int unsigned n_items);
        int unsigned sent;
        int unsigned burst;
        int unsigned enq_pct;
        int unsigned k;
        sent = 0;
        while (sent < n_items) begin
            burst   = $urandom_range(20, 60);
            enq_pct = $urandom_range(5, 95);
            calm    = (sent >= n_items / 3) && (sent < n_items / 2);
            for (k = 0; k < burst && sent < n_items; k++) begin
                if ($urandom_range(0, 99) < enq_pct)
                    send_cmd(OP_ENQUEUE, 8'($urandom));
                else
                    send_cmd(OP_DEQUEUE, 8'($urandom));
                sent++;
            end
        end
        calm = 1'b0;
    endtask

    // Main sequence.
    initial begin
        int n;
        cmd_ch.valid   = 1'b0;
        cmd_ch.kind    = OP_ENQUEUE;
        cmd_ch.data_in = '0;
        i_rst_n        = 1'b0;
        for (n = 0; n < DEPTH; n++) begin
            lane_bytes[0][n] = DASH;
            lane_bytes[1][n] = DASH;
        end
        lane_len[0] = 0;
        lane_len[1] = 0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_dequeue();
        test_fill_and_drop();
        test_random_traffic(1527);

        // Stop sending and let the last results drain.
        cmd_ch.valid <= 1'b0;
        for (n = 0; n < 2000 && pending_results.size() != 0; n++)
            @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        if (pending_results.size() != 0)
            flag_mismatch("results never delivered", 0, pending_results.size());

        $display("Sent %0d commands and checked %0d results, with both queues filled,",
                 items_sent, results_seen);
        $display("drained and overflowed: %0d enqueues dropped, %0d dequeues on empty.",
                 drops_seen, empties_seen);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
